// ===== rtl/fpa_pkg.sv =====
// Shared types, sizes and codes for the fit partition allocator.
package fpa_pkg;

  localparam int NUM_PARTITIONS = 8;
  localparam int SIZE_BITS      = 16;
  localparam int IDX_BITS       = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int AMOUNT_BITS    = 16;
  localparam int CMP_BITS       = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  typedef struct packed {
    logic                   cmd;
    logic [2:0]             partition_index;
    logic [AMOUNT_BITS-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic                   granted;
    logic [2:0]             chosen_partition;
    logic [AMOUNT_BITS-1:0] space_left;
  } out_item_t;

  typedef struct packed {
    logic                   active;
    logic [1:0]             mode;
    logic [AMOUNT_BITS-1:0] amount;
    logic                   found;
    logic [IDX_BITS-1:0]    pick;
    logic [SIZE_BITS-1:0]   best;
  } token_t;

endpackage

// ===== rtl/fit_partition_allocator.sv =====
// Top level of the fit partition allocator with its row of partition cells.
// A load transaction gives its result in the cycle after acceptance.
// An allocate transaction walks the cell row one cell per cycle, through the entry
// token register and each cell's token register, and its result is then registered.
// One transaction is in flight at a time; the next is taken as the result leaves.
// Synchronous reset clears every free size to zero and the fit mode to first fit.
module fit_partition_allocator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  fpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fpa_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data
);
  import fpa_pkg::*;

  logic       [1:0] fit_mode;
  logic             busy;
  logic             in_acc;
  logic             done;
  token_t           tokens [NUM_PARTITIONS+1];
  token_t           last;
  logic [CMP_BITS-1:0] left;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign last      = tokens[NUM_PARTITIONS];
  assign done      = last.active;
  assign left      = CMP_BITS'(last.best) - CMP_BITS'(last.amount);

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= MODE_FIRST;
    end else if (cfg_valid && cfg_ready) begin
      fit_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tokens[0].active <= 1'b0;
    end else begin
      tokens[0].active <= in_acc && in_data.cmd == CMD_ALLOC;
    end
    tokens[0].mode   <= fit_mode;
    tokens[0].amount <= in_data.amount;
    tokens[0].found  <= 1'b0;
    tokens[0].pick   <= '0;
    tokens[0].best   <= '0;
  end

  genvar i;
  generate
    for (i = 0; i < NUM_PARTITIONS; i++) begin : g_cell
      logic load_en;
      assign load_en = in_acc && in_data.cmd == CMD_LOAD
                       && 32'(in_data.partition_index) == i;
      fpa_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .cell_idx      (IDX_BITS'(i)),
        .load_en       (load_en),
        .load_value    (in_data.amount),
        .commit_en     (done && last.found),
        .commit_pick   (last.pick),
        .commit_amount (last.amount),
        .token_in      (tokens[i]),
        .token_out     (tokens[i+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc && in_data.cmd == CMD_ALLOC) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (in_acc && in_data.cmd == CMD_LOAD) begin
        out_valid <= 1'b1;
      end else if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (in_acc && in_data.cmd == CMD_LOAD) begin
      out_data <= '0;
    end else if (done) begin
      out_data.granted          <= last.found;
      out_data.chosen_partition <= last.found ? 3'(last.pick) : 3'd0;
      out_data.space_left       <= last.found ? AMOUNT_BITS'(left) : '0;
    end
  end

endmodule

// ===== rtl/fpa_cell.sv =====
// One partition cell: holds a free size and updates the passing search token.
module fpa_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [fpa_pkg::IDX_BITS-1:0]   cell_idx,
  input  logic                           load_en,
  input  logic [fpa_pkg::AMOUNT_BITS-1:0] load_value,
  input  logic                           commit_en,
  input  logic [fpa_pkg::IDX_BITS-1:0]   commit_pick,
  input  logic [fpa_pkg::AMOUNT_BITS-1:0] commit_amount,
  input  fpa_pkg::token_t                token_in,
  output fpa_pkg::token_t                token_out
);
  import fpa_pkg::*;

  logic [SIZE_BITS-1:0] space;
  logic                 fits;
  logic                 better;
  logic                 take;
  token_t               token_next;

  always_comb begin
    fits = CMP_BITS'(space) >= CMP_BITS'(token_in.amount);
    case (token_in.mode)
      MODE_BEST:  better = space < token_in.best;
      MODE_WORST: better = space > token_in.best;
      default:    better = 1'b0;
    endcase
    take = fits && (!token_in.found || better);
    token_next = token_in;
    if (take) begin
      token_next.found = 1'b1;
      token_next.pick  = cell_idx;
      token_next.best  = space;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space <= '0;
    end else if (load_en) begin
      space <= SIZE_BITS'(load_value);
    end else if (commit_en && commit_pick == cell_idx) begin
      space <= space - SIZE_BITS'(commit_amount);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_out.active <= 1'b0;
    end else begin
      token_out.active <= token_in.active;
    end
    token_out.mode   <= token_next.mode;
    token_out.amount <= token_next.amount;
    token_out.found  <= token_next.found;
    token_out.pick   <= token_next.pick;
    token_out.best   <= token_next.best;
  end

endmodule

// ===== test/fit_partition_allocator_test.sv =====
// Self-checking testbench for the fit partition allocator: directed and random transactions.
`timescale 1ns / 1ps

module fit_partition_allocator_test;
  import fpa_pkg::*;

  localparam logic [1:0] MODE_UNDEFINED = 2'd3;
  localparam int PHASE_ITEMS = 150;
  localparam int SETTLE_CYCLES = NUM_PARTITIONS + 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;

  in_item_t pending_items[$];
  out_item_t expected_grants[$];
  logic [SIZE_BITS-1:0] free_table[NUM_PARTITIONS];
  logic [1:0] fit_rule = MODE_FIRST;
  logic in_accepted = 1'b0;
  logic idle_on = 1'b1;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold_cycles = 0;
  int error_count = 0;

  fit_partition_allocator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_item_t place_request(in_item_t item);
    out_item_t res;
    logic found;
    int pick;
    res = '0;
    found = 1'b0;
    pick = 0;
    if (item.cmd == CMD_LOAD) begin
      if (item.partition_index < NUM_PARTITIONS) begin
        free_table[item.partition_index] = item.amount[SIZE_BITS-1:0];
      end
      return res;
    end
    for (int j = 0; j < NUM_PARTITIONS; j++) begin
      if (free_table[j] >= item.amount) begin
        if (!found) begin
          found = 1'b1;
          pick = j;
          if (fit_rule != MODE_BEST && fit_rule != MODE_WORST) break;
        end else if (fit_rule == MODE_BEST && free_table[j] < free_table[pick]) begin
          pick = j;
        end else if (fit_rule == MODE_WORST && free_table[j] > free_table[pick]) begin
          pick = j;
        end
      end
    end
    if (found) begin
      free_table[pick] = free_table[pick] - item.amount[SIZE_BITS-1:0];
      res.granted = 1'b1;
      res.chosen_partition = pick[2:0];
      res.space_left = free_table[pick];
    end
    return res;
  endfunction

  function automatic in_item_t random_request();
    in_item_t item;
    int roll;
    item.cmd = ($urandom_range(0, 99) < 35) ? CMD_LOAD : CMD_ALLOC;
    item.partition_index = 3'($urandom_range(0, 7));
    roll = $urandom_range(0, 19);
    if (item.cmd == CMD_LOAD) begin
      if (roll < 10) item.amount = AMOUNT_BITS'($urandom_range(0, 65535));
      else if (roll < 16) item.amount = AMOUNT_BITS'($urandom_range(0, 4) * 1000);
      else if (roll < 18) item.amount = (roll == 16) ? '0 : '1;
      else item.amount = AMOUNT_BITS'($urandom_range(0, 255));
    end else begin
      if (roll < 12) item.amount = AMOUNT_BITS'($urandom_range(0, 2000));
      else if (roll < 15) item.amount = AMOUNT_BITS'($urandom_range(0, 65535));
      else if (roll < 18) item.amount = AMOUNT_BITS'($urandom_range(0, 4) * 1000);
      else item.amount = (roll == 18) ? '0 : '1;
    end
    return item;
  endfunction

  task automatic queue_item(logic cmd, logic [2:0] idx, logic [AMOUNT_BITS-1:0] amount);
    in_item_t item;
    item.cmd = cmd;
    item.partition_index = idx;
    item.amount = amount;
    pending_items.push_back(item);
  endtask

  task automatic write_fit_mode(logic [1:0] mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    fit_rule = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_items.size() != 0 || in_valid);
    while (expected_grants.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    in_accepted = !rst && in_valid && !in_stall;
    if (in_accepted) begin
      expected_grants.push_back(place_request(in_data));
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transaction, actual %p", $time, out_data);
      end else begin
        out_item_t want;
        want = expected_grants.pop_front();
        if (out_data.granted !== want.granted) begin
          error_count++;
          $display("%0t: granted expected %0d actual %0d", $time, want.granted,
                   out_data.granted);
        end
        if (out_data.chosen_partition !== want.chosen_partition) begin
          error_count++;
          $display("%0t: chosen_partition expected %0d actual %0d", $time,
                   want.chosen_partition, out_data.chosen_partition);
        end
        if (out_data.space_left !== want.space_left) begin
          error_count++;
          $display("%0t: space_left expected %0d actual %0d", $time, want.space_left,
                   out_data.space_left);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      out_stall <= 1'b1;
      rx_hold_cycles--;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      out_stall <= 1'b1;
      rx_gap = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [1:0] phase_modes[8];
    phase_modes = '{MODE_BEST, MODE_WORST, MODE_FIRST, MODE_UNDEFINED,
                    MODE_WORST, MODE_BEST, MODE_FIRST, MODE_BEST};
    for (int i = 0; i < NUM_PARTITIONS; i++) free_table[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_fit_mode(MODE_FIRST);
    queue_item(CMD_ALLOC, 3'd7, 16'd0);
    queue_item(CMD_ALLOC, 3'd0, 16'd1);
    queue_item(CMD_LOAD, 3'd0, 16'd100);
    queue_item(CMD_LOAD, 3'd1, 16'd30);
    queue_item(CMD_LOAD, 3'd2, 16'hFFFF);
    queue_item(CMD_LOAD, 3'd3, 16'd30);
    queue_item(CMD_LOAD, 3'd4, 16'd0);
    queue_item(CMD_LOAD, 3'd5, 16'd500);
    queue_item(CMD_LOAD, 3'd6, 16'd1);
    queue_item(CMD_LOAD, 3'd7, 16'd30);
    queue_item(CMD_ALLOC, 3'd5, 16'hFFFF);
    queue_item(CMD_ALLOC, 3'd2, 16'hFFFF);
    queue_item(CMD_ALLOC, 3'd0, 16'd30);
    wait_drained();
    write_fit_mode(MODE_BEST);
    queue_item(CMD_ALLOC, 3'd0, 16'd30);
    queue_item(CMD_ALLOC, 3'd6, 16'd0);
    wait_drained();
    write_fit_mode(MODE_WORST);
    queue_item(CMD_ALLOC, 3'd0, 16'd10);
    queue_item(CMD_ALLOC, 3'd3, 16'd0);
    wait_drained();
    write_fit_mode(MODE_UNDEFINED);
    queue_item(CMD_ALLOC, 3'd1, 16'd1);
    queue_item(CMD_ALLOC, 3'd4, 16'd40000);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_fit_mode(phase_modes[p]);
      if (p == 1) begin
        @(posedge clk);
        rx_hold_cycles = 150;
      end
      if (p == 7) idle_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(random_request());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fpa_pkg.sv
rtl/fpa_cell.sv
rtl/fit_partition_allocator.sv
test/fit_partition_allocator_test.sv
